>>> design/hbd_pkg.sv
// ----------------------------------------------------------------------------
// hbd_pkg: shared types and constants for the hysteresis band decoder
// Transfer structs, operation codes, drive codes and parameter defaults.
// ----------------------------------------------------------------------------
package hbd_pkg;

  localparam int TableSizeDefault  = 13;
  localparam int SampleBitsDefault = 16;
  localparam int BandW             = 4;

  localparam logic [BandW-1:0] VhfFirstReset = 4'd10;

  // operation codes
  localparam logic [1:0] OpSample  = 2'd0;
  localparam logic [1:0] OpWrUpper = 2'd1;
  localparam logic [1:0] OpWrLower = 2'd2;

  // tuner line codes
  localparam logic [BandW-1:0] LinesAllOff = 4'hF;
  localparam logic [BandW-1:0] LinesVhf    = 4'h0;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [BandW-1:0] entry;
    logic [15:0]      value;
  } in_item_t;

  typedef struct packed {
    logic [BandW-1:0] band;
    logic [BandW-1:0] band_lines;
    logic             power_on;
    logic             settle;
    logic             last;
  } out_item_t;

  // threshold table write control
  typedef struct packed {
    logic             upper_we;
    logic             lower_we;
    logic [BandW-1:0] entry;
  } thr_wr_t;

endpackage

>>> design/hbd_thr_mem.sv
// ----------------------------------------------------------------------------
// hbd_thr_mem: threshold tables and shared comparator
// Holds the upper and lower threshold tables and the one magnitude compare
// that the band walk reuses every cycle.
// ----------------------------------------------------------------------------
module hbd_thr_mem #(
  parameter int TABLE_SIZE  = hbd_pkg::TableSizeDefault,
  parameter int SAMPLE_BITS = hbd_pkg::SampleBitsDefault,
  localparam int IdxW       = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1
) (
  input  logic                   clk_i,
  input  hbd_pkg::thr_wr_t       wr_i,
  input  logic [SAMPLE_BITS-1:0] wr_value_i,
  input  logic [IdxW-1:0]        rd_idx_i,
  input  logic                   cmp_upper_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   lt_o
);
  import hbd_pkg::*;

  logic [SAMPLE_BITS-1:0] upper_q [TABLE_SIZE];
  logic [SAMPLE_BITS-1:0] lower_q [TABLE_SIZE];
  logic [SAMPLE_BITS-1:0] cmp_a, cmp_b;

  always_ff @(posedge clk_i) begin
    if (wr_i.upper_we) begin
      upper_q[wr_i.entry[IdxW-1:0]] <= wr_value_i;
    end
    if (wr_i.lower_we) begin
      lower_q[wr_i.entry[IdxW-1:0]] <= wr_value_i;
    end
  end

  // walking up: upper < sample; walking down: sample < lower
  always_comb begin
    if (cmp_upper_i) begin
      cmp_a = upper_q[rd_idx_i];
      cmp_b = sample_i;
    end else begin
      cmp_a = sample_i;
      cmp_b = lower_q[rd_idx_i];
    end
  end

  assign lt_o = cmp_a < cmp_b;

endmodule

>>> design/hysteresis_band_decoder.sv
// ----------------------------------------------------------------------------
// hysteresis_band_decoder: multilevel quantiser with hysteresis
// Walks a band index over loaded threshold tables and drives tuner codes.
// ----------------------------------------------------------------------------
//  channel | signals                          | direction
//  in      | in_valid_i, in_stall_o, in_data_i | sample / table load items
//  out     | out_valid_o, out_stall_i, out_data_o | band and drive results
//  cfg     | cfg_we_i, cfg_data_i             | vhf_first_band write
//
// A table load is written while idle. A sample walks the band index up,
// then down, one compare per step on the shared comparator and at most
// 2*(TABLE_SIZE-1) steps together, before its first result is registered;
// leaving a nonzero band below vhf_first_band gives a settle result, then
// the final one. Input is stalled while a sample is in work. Output stalls
// hold the result register. Reset sets band 0, lines 0 and power off.
// ----------------------------------------------------------------------------
module hysteresis_band_decoder #(
  parameter int TABLE_SIZE  = hbd_pkg::TableSizeDefault,
  parameter int SAMPLE_BITS = hbd_pkg::SampleBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  hbd_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hbd_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_data_i
);
  import hbd_pkg::*;

  localparam int IdxW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam logic [BandW-1:0] TableTop = BandW'(TABLE_SIZE - 1);
  localparam logic [BandW:0]   TableLen = (BandW + 1)'(TABLE_SIZE);

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StUp     = 5'b00010,
    StDown   = 5'b00100,
    StResult = 5'b01000,
    StFinal  = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic [BandW-1:0]       idx_q, idx_d;
  logic [BandW-1:0]       cur_q, cur_d;
  logic [BandW-1:0]       line_q, line_d;
  logic                   pwr_q, pwr_d;
  logic [BandW-1:0]       vhf_q;
  logic [SAMPLE_BITS-1:0] val_q, val_d;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;

  thr_wr_t                thr_wr;
  logic                   lt;
  logic                   accept;
  logic                   slot_free;
  logic                   entry_ok;
  logic [BandW-1:0]       drv_band;
  logic [BandW-1:0]       drv_line;
  logic                   drv_pwr;
  logic                   cur_hf;

  assign in_stall_o  = (state_q != StIdle);
  assign accept      = in_valid_i && (state_q == StIdle);
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign entry_ok        = {1'b0, in_data_i.entry} < TableLen;
  assign thr_wr.upper_we = accept && (in_data_i.opcode == OpWrUpper) && entry_ok;
  assign thr_wr.lower_we = accept && (in_data_i.opcode == OpWrLower) && entry_ok;
  assign thr_wr.entry    = in_data_i.entry;

  hbd_thr_mem #(
    .TABLE_SIZE  (TABLE_SIZE),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_thr_mem (
    .clk_i       (clk_i),
    .wr_i        (thr_wr),
    .wr_value_i  (in_data_i.value[SAMPLE_BITS-1:0]),
    .rd_idx_i    (idx_q[IdxW-1:0]),
    .cmp_upper_i (state_q == StUp),
    .sample_i    (val_q),
    .lt_o        (lt)
  );

  assign cur_hf = (cur_q != '0) && (cur_q < vhf_q);

  // drive code for the target band; band 0 keeps the lines
  assign drv_band = (state_q == StFinal) ? cur_q : idx_q;
  always_comb begin
    if (drv_band == '0) begin
      drv_line = line_q;
      drv_pwr  = 1'b0;
    end else if (drv_band >= vhf_q) begin
      drv_line = LinesVhf;
      drv_pwr  = 1'b1;
    end else begin
      drv_line = ~drv_band;
      drv_pwr  = 1'b1;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    line_d      = line_q;
    pwr_d       = pwr_q;
    val_d       = val_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    case (state_q)
      StIdle: begin
        if (accept && (in_data_i.opcode == OpSample)) begin
          val_d   = in_data_i.value[SAMPLE_BITS-1:0];
          idx_d   = cur_q;
          state_d = StUp;
        end
      end
      StUp: begin
        if ((idx_q != TableTop) && lt) begin
          idx_d = idx_q + 1'b1;
        end else begin
          state_d = StDown;
        end
      end
      StDown: begin
        if ((idx_q != '0) && lt) begin
          idx_d = idx_q - 1'b1;
        end else begin
          state_d = StResult;
        end
      end
      StResult: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          if (idx_q == cur_q) begin
            out_d   = '{band: cur_q, band_lines: line_q, power_on: pwr_q,
                        settle: 1'b0, last: 1'b1};
            state_d = StIdle;
          end else if (cur_hf) begin
            // all lines off while the relays settle
            cur_d   = idx_q;
            line_d  = LinesAllOff;
            out_d   = '{band: idx_q, band_lines: LinesAllOff, power_on: pwr_q,
                        settle: 1'b1, last: 1'b0};
            state_d = StFinal;
          end else begin
            cur_d   = idx_q;
            line_d  = drv_line;
            pwr_d   = drv_pwr;
            out_d   = '{band: idx_q, band_lines: drv_line, power_on: drv_pwr,
                        settle: 1'b0, last: 1'b1};
            state_d = StIdle;
          end
        end
      end
      StFinal: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          line_d      = drv_line;
          pwr_d       = drv_pwr;
          out_d       = '{band: cur_q, band_lines: drv_line, power_on: drv_pwr,
                          settle: 1'b0, last: 1'b1};
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cur_q       <= '0;
      line_q      <= '0;
      pwr_q       <= 1'b0;
      vhf_q       <= VhfFirstReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      line_q      <= line_d;
      pwr_q       <= pwr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        vhf_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    val_q <= val_d;
    out_q <= out_d;
  end

endmodule

>>> design/hbd_checker.sv
// ----------------------------------------------------------------------------
// hbd_checker: port-level checks for the hysteresis band decoder
// Watches the transfer ports and flags results that break the drive rules.
// ----------------------------------------------------------------------------
module hbd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input hbd_pkg::in_item_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input hbd_pkg::out_item_t out_data_o
);
  import hbd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_settle_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.settle |-> !out_data_o.last &&
      (out_data_o.band_lines == LinesAllOff))
    else $error("settle result malformed");

  a_power_off_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last && !out_data_o.power_on |->
      (out_data_o.band == '0))
    else $error("power off outside the through band");

  a_busy_after_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.opcode == OpSample) |=> in_stall_o)
    else $error("sample transfer not followed by busy");

endmodule

bind hysteresis_band_decoder hbd_checker u_hbd_checker (.*);
